// ===== rtl/tdf_pkg.sv =====
// Shared widths, job record and back-end state type for the Tanimoto distance filter.
package tdf_pkg;

    localparam int WORD_W   = 64;
    localparam int ID_W     = 32;
    localparam int POP_W    = 7;
    localparam int CNT_W    = 10;
    localparam int DEN_W    = CNT_W + 1;
    localparam int FRAC_W   = 16;
    localparam int DIST_W   = FRAC_W + 1;
    localparam int STEP_W   = $clog2(FRAC_W);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [DIST_W-1:0] DIST_ONE  = DIST_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_W - 1);

    typedef struct packed {
        logic [ID_W-1:0]  ref_id;
        logic [ID_W-1:0]  cmp_id;
        logic [CNT_W-1:0] ref_cnt;
        logic [CNT_W-1:0] cmp_cnt;
        logic [CNT_W-1:0] common_cnt;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/tdf_front.sv =====
// Front end: per-word popcounts and saturating bit totals, hands finished pairs to the queue.
module tdf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [tdf_pkg::WORD_W-1:0] i_ref_word,
    input  logic [tdf_pkg::WORD_W-1:0] i_cmp_word,
    input  logic                       i_last_word,
    input  logic [tdf_pkg::ID_W-1:0]   i_ref_id,
    input  logic [tdf_pkg::ID_W-1:0]   i_cmp_id,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output tdf_pkg::t_job              o_q_job
);
    import tdf_pkg::*;

    function automatic logic [POP_W-1:0] ones64(input logic [WORD_W-1:0] w);
        logic [3:0]       bcnt [8];
        logic [POP_W-1:0] s;
        for (int b = 0; b < 8; b++) begin
            bcnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                bcnt[b] = bcnt[b] + {3'b000, w[b*8+k]};
            end
        end
        s = '0;
        for (int b = 0; b < 8; b++) begin
            s = s + {{(POP_W-4){1'b0}}, bcnt[b]};
        end
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                 input logic [POP_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, acc} + {{(CNT_W+1-POP_W){1'b0}}, n};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    logic [CNT_W-1:0] r_ref_cnt, r_cmp_cnt, r_common_cnt;
    logic [CNT_W-1:0] n_ref_cnt, n_cmp_cnt, n_common_cnt;
    logic             accept;

    assign accept = i_push & ~i_q_full;

    always_comb begin
        n_ref_cnt    = sat_add(r_ref_cnt, ones64(i_ref_word));
        n_cmp_cnt    = sat_add(r_cmp_cnt, ones64(i_cmp_word));
        n_common_cnt = sat_add(r_common_cnt, ones64(i_ref_word & i_cmp_word));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_cnt    <= '0;
            r_cmp_cnt    <= '0;
            r_common_cnt <= '0;
        end else if (accept) begin
            if (i_last_word) begin
                r_ref_cnt    <= '0;
                r_cmp_cnt    <= '0;
                r_common_cnt <= '0;
            end else begin
                r_ref_cnt    <= n_ref_cnt;
                r_cmp_cnt    <= n_cmp_cnt;
                r_common_cnt <= n_common_cnt;
            end
        end
    end

    assign o_q_push           = accept & i_last_word;
    assign o_q_job.ref_id     = i_ref_id;
    assign o_q_job.cmp_id     = i_cmp_id;
    assign o_q_job.ref_cnt    = n_ref_cnt;
    assign o_q_job.cmp_cnt    = n_cmp_cnt;
    assign o_q_job.common_cnt = n_common_cnt;

    // AND bits can never outnumber either side, saturation included
    a_common_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_common_cnt <= r_ref_cnt) && (r_common_cnt <= r_cmp_cnt))
        else $error("common total above a side total");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_ref_cnt == '0) && (r_cmp_cnt == '0) && (r_common_cnt == '0))
        else $error("totals not cleared after last word");

endmodule

// ===== rtl/tdf_queue.sv =====
// Short job queue between the popcount front end and the divider.
module tdf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tdf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tdf_pkg::t_job o_job
);
    import tdf_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr, rd;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push & ~o_full;
    assign rd      = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/tdf_back.sv =====
// Back end: denominator, 16-step restoring divide, threshold compare and result register.
module tdf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  tdf_pkg::t_job              i_q_job,
    output logic                       o_q_pop,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tdf_pkg::DIST_W-1:0] i_cfg_threshold_q16,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [tdf_pkg::ID_W-1:0]   o_pair_ref_id,
    output logic [tdf_pkg::ID_W-1:0]   o_pair_cmp_id,
    output logic [tdf_pkg::DIST_W-1:0] o_distance_q16,
    output logic                       o_above_threshold
);
    import tdf_pkg::*;

    t_back_state       r_state, n_state;
    logic [DIST_W-1:0] r_thr;
    logic [DEN_W-1:0]  r_den, r_rem;
    logic [CNT_W-1:0]  r_common;
    logic [FRAC_W-1:0] r_quot;
    logic [STEP_W-1:0] r_step;
    logic [DIST_W-1:0] r_dist;
    logic [ID_W-1:0]   r_ref_id, r_cmp_id;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_ref_id, r_out_cmp_id;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_flag;

    logic              out_free, load_out;
    logic [DEN_W:0]    shifted;
    logic              ge;
    logic [DEN_W:0]    trial;

    assign out_free = ~r_out_valid | i_pop;
    assign shifted  = {r_rem, 1'b0};
    assign ge       = (shifted >= {1'b0, r_den});
    assign trial    = shifted - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_PREP;
            ST_PREP: begin
                // empty pair or nothing in common: result known without dividing
                if ((r_den == '0) || (r_common == '0)) n_state = ST_DONE;
                else                                   n_state = ST_DIV;
            end
            ST_DIV:  if (r_step == STEP_LAST) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_q_pop  = ~i_q_empty;
            ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_threshold_q16;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_den    <= {1'b0, i_q_job.ref_cnt} + {1'b0, i_q_job.cmp_cnt}
                        - {1'b0, i_q_job.common_cnt};
            r_common <= i_q_job.common_cnt;
            r_ref_id <= i_q_job.ref_id;
            r_cmp_id <= i_q_job.cmp_id;
        end
        if (r_state == ST_PREP) begin
            // numerator is den - common, below den whenever the divide runs
            r_rem  <= r_den - {1'b0, r_common};
            r_quot <= '0;
            r_step <= '0;
            r_dist <= (r_den == '0) ? '0 : DIST_ONE;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quot <= {r_quot[FRAC_W-2:0], ge};
            r_step <= r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                r_dist <= {1'b0, r_quot[FRAC_W-2:0], ge};
            end
        end
        if (load_out) begin
            r_out_ref_id <= r_ref_id;
            r_out_cmp_id <= r_cmp_id;
            r_out_dist   <= r_dist;
            r_out_flag   <= (r_dist > r_thr);
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_empty           = ~r_out_valid;
    assign o_pair_ref_id     = r_out_ref_id;
    assign o_pair_cmp_id     = r_out_cmp_id;
    assign o_distance_q16    = r_out_dist;
    assign o_above_threshold = r_out_flag;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below denominator");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dist <= DIST_ONE))
        else $error("distance above one");

    a_flag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flag) |-> (r_out_dist != '0))
        else $error("flag raised on zero distance");

endmodule

// ===== rtl/tanimoto_distance_filter.sv =====
// Tanimoto distance filter top level: front end, job queue and divider back end.
// One word pair per cycle while full is low; full rises only while the two-entry job queue is full.
// The back end handles one finished pair at a time (pop, prepare, 16 divide steps, result load),
// no divide when both fingerprints are empty or share no bits; shorter pairs back up into the queue.
// With the back end idle, empty falls once the last word's job is popped, divided and loaded.
// Reset is synchronous, active low: bit totals, queue, divider state, valid flag and threshold clear.
module tanimoto_distance_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [tdf_pkg::WORD_W-1:0] i_ref_word,
    input  logic [tdf_pkg::WORD_W-1:0] i_cmp_word,
    input  logic                       i_last_word,
    input  logic [tdf_pkg::ID_W-1:0]   i_ref_id,
    input  logic [tdf_pkg::ID_W-1:0]   i_cmp_id,
    output logic                       empty,
    input  logic                       pop,
    output logic [tdf_pkg::ID_W-1:0]   o_pair_ref_id,
    output logic [tdf_pkg::ID_W-1:0]   o_pair_cmp_id,
    output logic [tdf_pkg::DIST_W-1:0] o_distance_q16,
    output logic                       o_above_threshold,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tdf_pkg::DIST_W-1:0] i_cfg_threshold_q16
);
    import tdf_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_job q_in_job, q_out_job;

    tdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_ref_word  (i_ref_word),
        .i_cmp_word  (i_cmp_word),
        .i_last_word (i_last_word),
        .i_ref_id    (i_ref_id),
        .i_cmp_id    (i_cmp_id),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job)
    );

    tdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out_job)
    );

    tdf_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_q_job             (q_out_job),
        .o_q_pop             (q_pop),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_threshold_q16 (i_cfg_threshold_q16),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_pair_ref_id       (o_pair_ref_id),
        .o_pair_cmp_id       (o_pair_cmp_id),
        .o_distance_q16      (o_distance_q16),
        .o_above_threshold   (o_above_threshold)
    );

    assign full = q_full;

endmodule
